// ===== design/round_robin_task_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler package
// Slot counts, field widths, request and response types and codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  localparam int unsigned TASK_COUNT = 5;
  localparam int unsigned SLOT_W     = $clog2(TASK_COUNT);
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned RUN_W      = 3;
  localparam int unsigned MASK_W     = 5;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_DELAY = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic              opcode;
    logic [TICK_W-1:0] delay_ticks;
  } req_t;

  typedef struct packed {
    logic [RUN_W-1:0]  running_task;
    logic [MASK_W-1:0] ready_mask;
    logic              delay_accepted;
    logic [TICK_W-1:0] tick_now;
  } rsp_t;

endpackage

`default_nettype wire

// ===== design/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler
// Tick and delay requests update wake times held in a RAM and blocked flags,
// then pick the next task in round-robin order, but for a delay on the idle task.
// A delay request goes from ST_IDLE to ST_DONE; a tick goes through ST_SCAN,
// where the RAM read port scans the wake times of the user slots in turn, and
// then ST_DONE, where the next task is picked and the response registered.
// The next request is taken back in ST_IDLE, and later while the previous
// response is held by a stall. One request is in work at a time.
// Reset clears the tick count, marks every task ready and runs slot one;
// the wake-time RAM is not cleared, as it is read only for blocked slots.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire rrts_pkg::req_t in_req_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output rrts_pkg::rsp_t      out_rsp_o
);

  import rrts_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_COUNT - 1);

  state_e                state_q, state_d;
  logic [TICK_W-1:0]     tick_q, tick_d;
  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [SLOT_W-1:0]     idx_q, idx_d;
  logic [TASK_COUNT-1:0] blocked_q, blocked_d;
  logic                  acc_q, acc_d;
  logic                  pick_en_q, pick_en_d;
  logic                  out_valid_q, out_valid_d;
  rsp_t                  rsp_q, rsp_d;

  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_waddr;
  logic [TICK_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [SLOT_W-1:0]     ram_raddr;
  logic [TICK_W-1:0]     ram_rdata;

  logic [SLOT_W-1:0]     pick_slot;
  logic [SLOT_W-1:0]     cur_next;
  logic [TASK_COUNT-1:0] ready_vec;
  logic [31:0]           ready_ext;
  logic [31:0]           cur_ext;
  logic                  accept;

  rrts_ram #(
    .WIDTH(TICK_W),
    .DEPTH(TASK_COUNT)
  ) u_wake_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rrts_pick u_pick (
    .cur_i    (cur_q),
    .blocked_i(blocked_q),
    .next_o   (pick_slot)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cur_next     = pick_en_q ? pick_slot : cur_q;
    ready_vec    = ~blocked_q;
    ready_vec[0] = 1'b1;
    ready_ext    = 32'(ready_vec);
    cur_ext      = 32'(cur_next);
  end

  always_comb begin
    state_d     = state_q;
    tick_d      = tick_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    blocked_d   = blocked_q;
    acc_d       = acc_q;
    pick_en_d   = pick_en_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    ram_we      = 1'b0;
    ram_waddr   = cur_q;
    ram_wdata   = tick_q + in_req_i.delay_ticks;
    ram_re      = 1'b0;
    ram_raddr   = idx_q + SLOT_W'(1);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_i.opcode == OP_TICK) begin
            tick_d    = tick_q + TICK_W'(1);
            acc_d     = 1'b0;
            pick_en_d = 1'b1;
            idx_d     = SLOT_W'(1);
            ram_re    = 1'b1;
            ram_raddr = SLOT_W'(1);
            state_d   = ST_SCAN;
          end else if (cur_q != '0) begin
            ram_we           = 1'b1;
            blocked_d[cur_q] = 1'b1;
            acc_d            = 1'b1;
            pick_en_d        = 1'b1;
            state_d          = ST_DONE;
          end else begin
            // The idle task cannot be delayed: report the state unchanged.
            acc_d     = 1'b0;
            pick_en_d = 1'b0;
            state_d   = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        // Read data belongs to idx_q; the next slot's read is issued alongside.
        if (blocked_q[idx_q] && (ram_rdata == tick_q)) begin
          blocked_d[idx_q] = 1'b0;
        end
        if (idx_q == LAST_SLOT) begin
          state_d = ST_DONE;
        end else begin
          idx_d  = idx_q + SLOT_W'(1);
          ram_re = 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cur_d                = cur_next;
          out_valid_d          = 1'b1;
          rsp_d.running_task   = cur_ext[RUN_W-1:0];
          rsp_d.ready_mask     = ready_ext[MASK_W-1:0];
          rsp_d.delay_accepted = acc_q;
          rsp_d.tick_now       = tick_q;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      cur_q       <= SLOT_W'(1);
      idx_q       <= '0;
      blocked_q   <= '0;
      acc_q       <= 1'b0;
      pick_en_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_q      <= tick_d;
      cur_q       <= cur_d;
      idx_q       <= idx_d;
      blocked_q   <= blocked_d;
      acc_q       <= acc_d;
      pick_en_q   <= pick_en_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ===== design/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== design/rrts_pick.sv =====
// ----------------------------------------------------------------------------
// Round-robin task picker
// Chooses the first ready user slot after the current one, wrapping round to
// the current slot itself, or the idle slot when no user slot is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_pick (
  input  wire logic [rrts_pkg::SLOT_W-1:0]     cur_i,
  input  wire logic [rrts_pkg::TASK_COUNT-1:0] blocked_i,
  output logic      [rrts_pkg::SLOT_W-1:0]     next_o
);

  import rrts_pkg::*;

  logic [TASK_COUNT-1:0] ready;
  logic [TASK_COUNT-1:0] above;
  logic [SLOT_W-1:0]     first_above;
  logic [SLOT_W-1:0]     first_any;

  always_comb begin
    ready    = ~blocked_i;
    ready[0] = 1'b0;
    for (int i = 0; i < TASK_COUNT; i++) begin
      above[i] = ready[i] && (SLOT_W'(i) > cur_i);
    end
  end

  // Two priority encoders: one above the current slot, one over all slots.
  always_comb begin
    first_above = '0;
    first_any   = '0;
    for (int i = TASK_COUNT - 1; i >= 1; i--) begin
      if (above[i]) begin
        first_above = SLOT_W'(i);
      end
      if (ready[i]) begin
        first_any = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    priority if (|above) begin
      next_o = first_above;
    end else if (|ready) begin
      next_o = first_any;
    end else begin
      next_o = '0;
    end
  end

endmodule

`default_nettype wire

// ===== design/rrts_checker.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler port checker
// Watches the top-level ports and checks the handshakes and the responses.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_task_scheduler_defines.svh"

module rrts_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire rrts_pkg::req_t in_req_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire rrts_pkg::rsp_t out_rsp_o
);

  import rrts_pkg::*;

  logic stalled;
  logic in_waiting;
  logic run_is_ready;

  assign stalled      = out_valid_o && !out_ready_i;
  assign in_waiting   = in_valid_i && !in_ready_o;
  assign run_is_ready = |((MASK_W'(1) << out_rsp_o.running_task) & out_rsp_o.ready_mask);

  // A waiting request keeps its valid and its payload.
  `RRTS_ASSERT_NEXT(a_in_hold, in_waiting, in_valid_i && $stable(in_req_i), "request dropped")

  // A stalled response keeps its valid and its payload.
  `RRTS_ASSERT_NEXT(a_out_hold, stalled, out_valid_o && $stable(out_rsp_o), "response dropped")

  // The idle slot is always reported ready.
  `RRTS_ASSERT_SAME(a_idle_ready, out_valid_o, out_rsp_o.ready_mask[0], "idle slot not ready")

  // A task chosen to run is never one that is blocked.
  `RRTS_ASSERT_SAME(a_run_ready, out_valid_o, run_is_ready, "running task is blocked")

  // Only one request is in work at a time.
  `RRTS_ASSERT_NEXT(a_one_busy, in_valid_i && in_ready_o, !in_ready_o, "second request taken")

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);

`default_nettype wire

// ===== test/round_robin_task_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// Round-robin task scheduler testbench
// Drives tick and delay requests through the valid/ready handshake with
// random idling on both sides, predicts each response from a local copy of
// the scheduler state, and checks every response field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_task_scheduler_tb;

  import rrts_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RANDOM_EVENTS = 1650;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic out_ready_i = 1'b0;
  req_t in_req_i    = '0;
  logic in_ready_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  round_robin_task_scheduler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  // Local copy of the scheduler state.
  logic [TICK_W-1:0] tick_cnt = '0;
  int unsigned       cur_slot = 1;
  logic [TICK_W-1:0] wake_at [TASK_COUNT];
  bit                blocked [TASK_COUNT];

  rsp_t        awaited_rsp [$];
  rsp_t        want;
  int unsigned err_cnt      = 0;
  int unsigned stall_cycles = 0;
  int unsigned gap_pct      = 25;
  bit          calm         = 1'b0;

  function automatic void pick_next_slot();
    int unsigned s;
    int unsigned i;
    s = cur_slot;
    for (i = 0; i < TASK_COUNT; i++) begin
      s = (s + 1) % TASK_COUNT;
      if (s != 0 && !blocked[s]) begin
        cur_slot = s;
        return;
      end
    end
    cur_slot = 0;
  endfunction

  // Applies one request to the local state and returns the response it gives.
  function automatic rsp_t schedule_event(opcode_e op, logic [TICK_W-1:0] dly);
    rsp_t        r;
    int unsigned i;
    r = '0;
    if (op == OP_TICK) begin
      tick_cnt = tick_cnt + 1'b1;
      for (i = 1; i < TASK_COUNT; i++) begin
        if (blocked[i] && wake_at[i] == tick_cnt) blocked[i] = 1'b0;
      end
      pick_next_slot();
    end else if (cur_slot != 0) begin
      wake_at[cur_slot] = tick_cnt + dly;
      blocked[cur_slot] = 1'b1;
      r.delay_accepted = 1'b1;
      pick_next_slot();
    end
    r.running_task = cur_slot[RUN_W-1:0];
    for (i = 0; i < TASK_COUNT && i < MASK_W; i++) begin
      r.ready_mask[i] = !blocked[i];
    end
    r.tick_now = tick_cnt;
    return r;
  endfunction

  task automatic send_req(opcode_e op, logic [TICK_W-1:0] dly);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= '{opcode: op, delay_ticks: dly};
    do @(posedge clk_i); while (!in_ready_o);
    awaited_rsp.push_back(schedule_event(op, dly));
  endtask

  // Plain ticks rotate through every user slot from the reset state.
  task automatic test_rotation();
    send_req(OP_TICK, '0);
    send_req(OP_TICK, '1);
    repeat (3) send_req(OP_TICK, $urandom());
  endtask

  // Short delays block a task; equal wake times release two tasks together.
  task automatic test_wake_on_tick();
    send_req(OP_DELAY, 32'd1);
    send_req(OP_TICK, $urandom());
    send_req(OP_DELAY, 32'd2);
    send_req(OP_DELAY, 32'd2);
    send_req(OP_TICK, $urandom());
    send_req(OP_TICK, $urandom());
  endtask

  // Every user task blocked: idle runs and ignores delay requests until a
  // tick wakes the tasks again.
  task automatic test_all_blocked();
    send_req(OP_DELAY, 32'd2);
    send_req(OP_DELAY, 32'd3);
    send_req(OP_DELAY, 32'd4);
    send_req(OP_DELAY, 32'd5);
    send_req(OP_DELAY, 32'hA5A5_5A5A);
    send_req(OP_DELAY, '1);
    repeat (6) send_req(OP_TICK, $urandom());
  endtask

  // Mostly short delays so tasks keep waking; tick payloads carry random bits.
  task automatic test_random_mix();
    int unsigned sent;
    logic [TICK_W-1:0] dly;
    sent = 0;
    while (sent < RANDOM_EVENTS) begin
      if (sent % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 12;
          default: gap_pct = 50;
        endcase
      end
      if ($urandom_range(0, 9) < 6) begin
        send_req(OP_TICK, $urandom());
      end else begin
        if ($urandom_range(0, 15) == 0) dly = $urandom_range(9, 40);
        else dly = $urandom_range(1, 8);
        send_req(OP_DELAY, dly);
      end
      sent++;
    end
  endtask

  // Zero and very long delays block their tasks for the rest of the run,
  // so they come last, with no idling on either side.
  task automatic test_extreme_delays();
    logic [TICK_W-1:0] vals [8];
    int unsigned       i;
    vals = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'hFFFF_FFFF};
    calm = 1'b1;
    for (i = 0; i < 8; i++) begin
      send_req(OP_TICK, $urandom());
      send_req(OP_TICK, $urandom());
      send_req(OP_DELAY, vals[i]);
    end
    repeat (4) send_req(OP_DELAY, $urandom());
    repeat (4) send_req(OP_TICK, $urandom());
  endtask

  // Response side: random stalls until the closing phase.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_rsp.size() == 0) begin
        $error("unexpected response: %p", out_rsp_o);
        err_cnt++;
      end else begin
        want = awaited_rsp.pop_front();
        if (out_rsp_o.running_task !== want.running_task) begin
          $error("running_task: expected %0d, got %0d", want.running_task,
                 out_rsp_o.running_task);
          err_cnt++;
        end
        if (out_rsp_o.ready_mask !== want.ready_mask) begin
          $error("ready_mask: expected %b, got %b", want.ready_mask,
                 out_rsp_o.ready_mask);
          err_cnt++;
        end
        if (out_rsp_o.delay_accepted !== want.delay_accepted) begin
          $error("delay_accepted: expected %b, got %b", want.delay_accepted,
                 out_rsp_o.delay_accepted);
          err_cnt++;
        end
        if (out_rsp_o.tick_now !== want.tick_now) begin
          $error("tick_now: expected %0d, got %0d", want.tick_now,
                 out_rsp_o.tick_now);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rotation();
    test_wake_on_tick();
    test_all_blocked();
    test_random_mix();
    test_extreme_delays();
    in_valid_i <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
